// ===== src/dtsg_pkg.sv =====
// Shared types, constants and the sine ROM builder of the dual tone sample generator.
// Depends on nothing; the design files refer to it by scoped names, the bench files import it.
package dtsg_pkg;

	localparam int FADE_LEN         = 220;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int PHASE_BITS       = 32;
	localparam int COUNT_BITS       = 24;

	localparam int STEP_W     = 32;
	localparam int LEN_W      = 24;
	localparam int SAMPLE_W   = 15;
	localparam int ROM_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_FIRST  = 2'd0,
		REG_STEP_SECOND = 2'd1,
		REG_DUAL        = 2'd2,
		REG_LENGTH      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [STEP_W-1:0] step_first;
		logic [STEP_W-1:0] step_second;
		logic              dual_enable;
		logic [LEN_W-1:0]  tone_length;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_ROM,
		ST_MIX,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic start;
		logic advance;
		logic rom_rd;
		logic mix;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic play;
		logic out_free;
	} stat_t;

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] K1 = 64'd1686629713;
	localparam logic [63:0] K3 = 64'd693598668;
	localparam logic [63:0] K5 = 64'd85569306;
	localparam logic [63:0] K7 = 64'd5026998;
	localparam logic [63:0] K9 = 64'd172271;

	// Sine value for a 32-bit angle fraction; only ever evaluated on constants.
	function automatic logic signed [ROM_W-1:0] sine_value(input logic [63:0] angle);
		logic [1:0]              quad;
		logic [63:0]             frac;
		logic [63:0]             u;
		logic [63:0]             s;
		logic [63:0]             p;
		logic [63:0]             r;
		logic [63:0]             v;
		logic signed [ROM_W-1:0] mag;
		quad = angle[31:30];
		frac = {34'd0, angle[29:0]};
		u = quad[0] ? (Q30_ONE - frac) : frac;
		s = (u * u) >> 30;
		p = K9;
		p = K7 - ((p * s) >> 30);
		p = K5 - ((p * s) >> 30);
		p = K3 - ((p * s) >> 30);
		p = K1 - ((p * s) >> 30);
		r = (p * u) >> 30;
		v = (r * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		mag = ROM_W'(v);
		return quad[1] ? -mag : mag;
	endfunction

endpackage

// ===== src/dtsg_cfg.sv =====
// Configuration register bank of the dual tone sample generator.
// Depends on dtsg_pkg for the register codes and the cfg_t bundle.
module dtsg_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dtsg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dtsg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output dtsg_pkg::cfg_t                   cfg
);

	dtsg_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (dtsg_pkg::cfg_reg_t'(cfg_index))
				dtsg_pkg::REG_STEP_FIRST: begin
					cfg_q.step_first <= dtsg_pkg::STEP_W'(cfg_data);
				end
				dtsg_pkg::REG_STEP_SECOND: begin
					cfg_q.step_second <= dtsg_pkg::STEP_W'(cfg_data);
				end
				dtsg_pkg::REG_DUAL: begin
					cfg_q.dual_enable <= cfg_data[0];
				end
				dtsg_pkg::REG_LENGTH: begin
					cfg_q.tone_length <= dtsg_pkg::LEN_W'(cfg_data);
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

endmodule

// ===== src/dtsg_ctrl.sv =====
// Sequencing state machine of the dual tone sample generator.
// Depends on dtsg_pkg for the state, command and status types.
module dtsg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_valid,
	output logic              tick_stall,
	input  dtsg_pkg::stat_t   stat,
	output dtsg_pkg::cmd_t    cmd
);

	dtsg_pkg::state_t state_q;
	dtsg_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dtsg_pkg::ST_IDLE: begin
				if (tick_valid && stat.play) begin
					state_nxt = dtsg_pkg::ST_ADDR;
				end
			end
			dtsg_pkg::ST_ADDR: begin
				state_nxt = dtsg_pkg::ST_ROM;
			end
			dtsg_pkg::ST_ROM: begin
				state_nxt = dtsg_pkg::ST_MIX;
			end
			dtsg_pkg::ST_MIX: begin
				state_nxt = dtsg_pkg::ST_DIV;
			end
			dtsg_pkg::ST_DIV: begin
				if (stat.out_free) begin
					state_nxt = dtsg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = dtsg_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		tick_stall = 1'b1;
		case (state_q)
			dtsg_pkg::ST_IDLE: begin
				tick_stall = 1'b0;
				cmd.start  = tick_valid;
			end
			dtsg_pkg::ST_ADDR: begin
				cmd.advance = 1'b1;
			end
			dtsg_pkg::ST_ROM: begin
				cmd.rom_rd = 1'b1;
			end
			dtsg_pkg::ST_MIX: begin
				cmd.mix = 1'b1;
			end
			dtsg_pkg::ST_DIV: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				tick_stall = 1'b1;
			end
		endcase
	end

	a_addr_follows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dtsg_pkg::ST_ADDR |-> $past(state_q) == dtsg_pkg::ST_IDLE && $past(tick_valid))
		else $error("sample work started without an accepted tick");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dtsg_pkg::ST_DIV && !stat.out_free |=> state_q == dtsg_pkg::ST_DIV)
		else $error("left the final step while the output register was full");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

endmodule

// ===== src/dtsg_dp.sv =====
// Datapath of the dual tone sample generator: phase accumulators, sine ROM,
// envelope, mixing multiply, reciprocal divide and output register. Depends on dtsg_pkg.
module dtsg_dp #(
	parameter int FadeLen   = dtsg_pkg::FADE_LEN,
	parameter int SineDepth = dtsg_pkg::SINE_TABLE_DEPTH,
	parameter int PhaseBits = dtsg_pkg::PHASE_BITS,
	parameter int CountBits = dtsg_pkg::COUNT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dtsg_pkg::cfg_t                      cfg,
	input  dtsg_pkg::cmd_t                      cmd,
	output dtsg_pkg::stat_t                     stat,
	input  logic                                restart,
	output logic                                smp_valid,
	input  logic                                smp_stall,
	output logic signed [dtsg_pkg::SAMPLE_W-1:0] sample,
	output logic                                last
);

	localparam int AddrW  = $clog2(SineDepth);
	localparam int DepthW = $clog2(SineDepth + 1);
	localparam int ProdW  = PhaseBits + DepthW;
	localparam int FadeW  = $clog2(FadeLen + 1);
	localparam int SumW   = ((CountBits > FadeW) ? CountBits : FadeW) + 1;
	localparam int MagW   = dtsg_pkg::ROM_W;
	localparam int MulW   = MagW + FadeW;
	localparam int DivInW = MulW - 1;
	localparam int DivSh  = DivInW + $clog2(FadeLen);
	localparam longint unsigned Recip = ((64'd1 << DivSh) + 64'(FadeLen) - 64'd1) / FadeLen;
	localparam int RecipW = $clog2(Recip + 1);
	localparam int DivPW  = DivInW + RecipW;

	// constant sine table, read through a registered port
	logic signed [dtsg_pkg::ROM_W-1:0] rom_w [SineDepth];

	for (genvar k = 0; k < SineDepth; k++) begin : g_rom
		localparam logic [63:0] Angle = (64'(k) << 32) / SineDepth;
		assign rom_w[k] = dtsg_pkg::sine_value(Angle);
	end

	logic [PhaseBits-1:0] phase1_q;
	logic [PhaseBits-1:0] phase2_q;
	logic [CountBits-1:0] count_q;
	logic                 playing_q;

	logic [AddrW-1:0]                  addr1_q;
	logic [AddrW-1:0]                  addr2_q;
	logic [FadeW-1:0]                  n_q;
	logic                              fin_q;
	logic signed [dtsg_pkg::ROM_W-1:0] sine1_q;
	logic signed [dtsg_pkg::ROM_W-1:0] sine2_q;
	logic [DivInW-1:0]                 divin_q;
	logic                              neg_q;

	logic                                 smp_valid_q;
	logic signed [dtsg_pkg::SAMPLE_W-1:0] sample_q;
	logic                                 last_q;

	logic [PhaseBits-1:0] step1;
	logic [PhaseBits-1:0] step2;
	logic [CountBits-1:0] total;
	logic [ProdW-1:0]     prod1;
	logic [ProdW-1:0]     prod2;
	logic [SumW-1:0]      i_ext;
	logic [SumW-1:0]      tot_ext;
	logic [SumW-1:0]      fade_ext;
	logic [FadeW-1:0]     n_nxt;
	logic                 fin_nxt;

	logic signed [dtsg_pkg::ROM_W:0]      mix;
	logic [MagW-1:0]                      mag;
	logic [MulW-1:0]                      mul;
	logic [DivInW-1:0]                    divin_nxt;
	logic [DivPW-1:0]                     dprod;
	logic signed [dtsg_pkg::SAMPLE_W-1:0] quot;
	logic signed [dtsg_pkg::SAMPLE_W-1:0] sample_nxt;

	assign step1 = PhaseBits'(cfg.step_first);
	assign step2 = PhaseBits'(cfg.step_second);
	assign total = CountBits'(cfg.tone_length);

	assign prod1 = ProdW'(phase1_q) * ProdW'(SineDepth);
	assign prod2 = ProdW'(phase2_q) * ProdW'(SineDepth);

	// envelope: ramp up, hold, ramp down; zero once past the end
	assign i_ext    = SumW'(count_q);
	assign tot_ext  = SumW'(total);
	assign fade_ext = SumW'(FadeLen);
	assign fin_nxt  = (i_ext + SumW'(1)) >= tot_ext;

	always_comb begin
		if (i_ext >= tot_ext) begin
			n_nxt = '0;
		end else if (i_ext < fade_ext) begin
			n_nxt = FadeW'(i_ext);
		end else if ((i_ext + fade_ext) > tot_ext) begin
			n_nxt = FadeW'(tot_ext - i_ext);
		end else begin
			n_nxt = FadeW'(fade_ext);
		end
	end

	assign stat.play     = restart ? (total != '0) : playing_q;
	assign stat.out_free = !smp_valid_q || !smp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase1_q  <= '0;
			phase2_q  <= '0;
			count_q   <= '0;
			playing_q <= 1'b0;
		end else if (cmd.start && restart) begin
			phase1_q  <= '0;
			phase2_q  <= '0;
			count_q   <= '0;
			playing_q <= (total != '0);
		end else if (cmd.advance) begin
			phase1_q <= phase1_q + step1;
			phase2_q <= phase2_q + step2;
			count_q  <= count_q + CountBits'(1);
			if (fin_nxt) begin
				playing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			addr1_q <= prod1[PhaseBits +: AddrW];
			addr2_q <= prod2[PhaseBits +: AddrW];
			n_q     <= n_nxt;
			fin_q   <= fin_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rom_rd) begin
			sine1_q <= rom_w[addr1_q];
			sine2_q <= rom_w[addr2_q];
		end
	end

	// work on the magnitude so the divide truncates toward zero
	assign mix = (dtsg_pkg::ROM_W + 1)'(sine1_q)
		+ (cfg.dual_enable ? (dtsg_pkg::ROM_W + 1)'(sine2_q) : '0);
	assign mag = MagW'(mix < 0 ? -mix : mix);
	assign mul = MulW'(mag) * MulW'(n_q);
	assign divin_nxt = cfg.dual_enable ? DivInW'(mul >> 2) : DivInW'(mul >> 1);

	always_ff @(posedge clk) begin
		if (cmd.mix) begin
			divin_q <= divin_nxt;
			neg_q   <= (mix < 0);
		end
	end

	// divide by the fade length through its rounded-up reciprocal
	assign dprod      = DivPW'(divin_q) * DivPW'(Recip);
	assign quot       = dtsg_pkg::SAMPLE_W'(dprod >> DivSh);
	assign sample_nxt = neg_q ? -quot : quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			smp_valid_q <= 1'b1;
		end else if (!smp_stall) begin
			smp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_q <= sample_nxt;
			last_q   <= fin_q;
		end
	end

	assign smp_valid = smp_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

	a_last_stops: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && fin_q |=> !playing_q)
		else $error("final sample delivered while still playing");

	a_silent_envelope: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && n_q == '0 |=> sample_q == '0)
		else $error("zero envelope gave a non-zero sample");

	a_advance_playing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> playing_q)
		else $error("phase advance while idle");

endmodule

// ===== src/dual_tone_sample_generator_top.sv =====
// Top level of the dual tone sample generator: config bank, controller, datapath.
// Depends on dtsg_pkg, dtsg_cfg, dtsg_ctrl and dtsg_dp.
//
//  channel | signals                              | direction | beat
//  tick    | tick_valid, tick_stall, restart      | in        | one sample tick
//  smp     | smp_valid, smp_stall, sample, last   | out       | one PCM sample
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | in        | one register write
//
// A tick that plays passes through the steps accept, ROM address multiply, registered ROM read,
// mix multiply and reciprocal divide; the divide step waits until the output register is free,
// loads the sample and returns to idle, where the next tick can be taken.
// An idle tick without restart is taken in the idle state and gives no sample.
// Reset clears config, phases, count and the playing flag; no clearing pass is needed.
// A stalled sample holds the output register; the next tick is taken meanwhile and
// its work waits in the final step until the register frees.
module dual_tone_sample_generator_top #(
	parameter int FadeLen   = dtsg_pkg::FADE_LEN,
	parameter int SineDepth = dtsg_pkg::SINE_TABLE_DEPTH,
	parameter int PhaseBits = dtsg_pkg::PHASE_BITS,
	parameter int CountBits = dtsg_pkg::COUNT_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 tick_valid,
	output logic                                 tick_stall,
	input  logic                                 restart,
	output logic                                 smp_valid,
	input  logic                                 smp_stall,
	output logic signed [dtsg_pkg::SAMPLE_W-1:0] sample,
	output logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dtsg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dtsg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	dtsg_pkg::cfg_t  cfg;
	dtsg_pkg::cmd_t  cmd;
	dtsg_pkg::stat_t stat;

	dtsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dtsg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick_valid),
		.tick_stall (tick_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	dtsg_dp #(
		.FadeLen   (FadeLen),
		.SineDepth (SineDepth),
		.PhaseBits (PhaseBits),
		.CountBits (CountBits)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.stat      (stat),
		.restart   (restart),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.sample    (sample),
		.last      (last)
	);

endmodule

// ===== dv/dtsg_checker.sv =====
// Scoreboard for the dual tone sample generator: watches the tick, config and sample
// channels, predicts every sample beat and compares it field by field. Depends on dtsg_pkg.
module dtsg_checker
	import dtsg_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tick_valid,
	input  logic                       tick_stall,
	input  logic                       restart,
	input  logic                       smp_valid,
	input  logic                       smp_stall,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       last,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	output int                         failures,
	output int                         pending
);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] level;
		logic                       fin;
	} pcm_beat_t;

	logic signed [16:0]    sine_lut [SINE_TABLE_DEPTH];
	pcm_beat_t             due_samples [$];

	logic [STEP_W-1:0]     step_a     = '0;
	logic [STEP_W-1:0]     step_b     = '0;
	logic                  dual_on    = 1'b0;
	logic [LEN_W-1:0]      length_cfg = '0;
	logic [PHASE_BITS-1:0] phase_a    = '0;
	logic [PHASE_BITS-1:0] phase_b    = '0;
	logic [COUNT_BITS-1:0] smp_index  = '0;
	logic                  playing    = 1'b0;
	int                    fails      = 0;

	// Q30 odd polynomial for a quarter wave, scaled to 32767 and rounded
	function automatic logic [63:0] quarter_level(input logic [63:0] u);
		logic [63:0] s;
		logic [63:0] p;
		logic [63:0] v;
		s = (u * u) >> 30;
		p = K9;
		p = K7 - ((p * s) >> 30);
		p = K5 - ((p * s) >> 30);
		p = K3 - ((p * s) >> 30);
		p = K1 - ((p * s) >> 30);
		v = ((((p * u) >> 30) * 64'd32767) + (Q30_ONE >> 1)) >> 30;
		return (v > 64'd32767) ? 64'd32767 : v;
	endfunction

	function automatic int rom_slot(input logic [PHASE_BITS-1:0] ph);
		logic [63:0] wide;
		wide = (64'(ph) * 64'(SINE_TABLE_DEPTH)) >> PHASE_BITS;
		return int'(wide % 64'(SINE_TABLE_DEPTH));
	endfunction

	initial begin : build_lut
		logic [63:0] a;
		logic [63:0] f;
		logic [63:0] mag;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			a = (64'(k) << 32) / 64'(SINE_TABLE_DEPTH);
			f = a & (Q30_ONE - 64'd1);
			mag = quarter_level(a[30] ? (Q30_ONE - f) : f);
			sine_lut[k] = a[31] ? -17'(mag) : 17'(mag);
		end
	end

	// Advance the tone by one tick and queue the sample it yields, if any
	task automatic next_sample(input logic rs);
		logic [63:0] total;
		logic [63:0] i;
		logic [63:0] n;
		int          mix;
		int          val;
		pcm_beat_t   beat;
		total = 64'(length_cfg);
		if (rs) begin
			phase_a = '0;
			phase_b = '0;
			smp_index = '0;
			playing = (total != 0);
		end
		if (!playing) begin
			return;
		end
		i = 64'(smp_index);
		if (i >= total) begin
			n = 0;
		end else if (i < FADE_LEN) begin
			n = i;
		end else if (i + FADE_LEN > total) begin
			n = total - i;
		end else begin
			n = FADE_LEN;
		end
		mix = int'(sine_lut[rom_slot(phase_a)]);
		if (dual_on) begin
			mix += int'(sine_lut[rom_slot(phase_b)]);
		end
		// signed division truncates toward zero
		val = (mix * int'(n)) / (dual_on ? 4 * FADE_LEN : 2 * FADE_LEN);
		beat.level = val[SAMPLE_W-1:0];
		beat.fin = (i + 1 >= total);
		due_samples.push_back(beat);
		phase_a = phase_a + step_a;
		phase_b = phase_b + step_b;
		smp_index = smp_index + 1'b1;
		if (beat.fin) begin
			playing = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pcm_beat_t want;
		if (!arst_n) begin
			step_a = '0;
			step_b = '0;
			dual_on = 1'b0;
			length_cfg = '0;
			phase_a = '0;
			phase_b = '0;
			smp_index = '0;
			playing = 1'b0;
			due_samples.delete();
			fails = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_STEP_FIRST: begin
						step_a = cfg_data[STEP_W-1:0];
					end
					REG_STEP_SECOND: begin
						step_b = cfg_data[STEP_W-1:0];
					end
					REG_DUAL: begin
						dual_on = cfg_data[0];
					end
					REG_LENGTH: begin
						length_cfg = cfg_data[LEN_W-1:0];
					end
					default: begin
					end
				endcase
			end
			// compare before predicting: a beat never leaves on the edge its tick enters
			if (smp_valid && !smp_stall) begin
				if (due_samples.size() == 0) begin
					$error("sample beat with nothing due: sample %0d, last %0b", sample, last);
					fails++;
				end else begin
					want = due_samples.pop_front();
					if (sample !== want.level) begin
						$error("sample: expected %0d, actual %0d", want.level, sample);
						fails++;
					end
					if (last !== want.fin) begin
						$error("last: expected %0b, actual %0b", want.fin, last);
						fails++;
					end
				end
			end
			if (tick_valid && !tick_stall) begin
				next_sample(restart);
			end
			failures <= fails;
			pending <= due_samples.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
// Top of the dual tone sample generator bench: clock, reset, tick and config stimulus,
// sample back-pressure and the verdict. Depends on dtsg_pkg, the block and dtsg_checker.
module tb;
	import dtsg_pkg::*;

	localparam int TICK_ITEMS  = 1550;
	localparam int QUIET_ITEMS = 150;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 200;

	typedef struct {
		cfg_reg_t               idx;
		logic [CFG_DATA_W-1:0]  data;
	} reg_write_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       tick_valid = 1'b0;
	logic                       restart    = 1'b0;
	logic                       smp_stall  = 1'b0;
	logic                       cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index  = '0;
	logic [CFG_DATA_W-1:0]      cfg_data   = '0;
	logic                       tick_stall;
	logic                       smp_valid;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;
	logic                       cfg_ready;
	int                         failures;
	int                         pending;

	bit                         tick_plan [$];
	reg_write_t                 reg_plan [$];
	int                         ticks_sent  = 0;
	int                         idle_cycles = 0;
	bit                         quiet       = 1'b0;
	bit                         noisy       = 1'b1;
	bit                         hold_req    = 1'b0;
	logic [LEN_W-1:0]           cur_len     = '0;

	dual_tone_sample_generator_top DUT (.*);

	dtsg_checker u_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((tick_valid && !tick_stall) || (smp_valid && !smp_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	// Sample sink: random stall bursts, one long hold on request, none near the end
	initial begin : sink
		int hold;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				smp_stall <= 1'b1;
				hold = HOLD_CYCLES;
			end else if (!quiet && noisy && $urandom_range(0, 5) == 0) begin
				smp_stall <= 1'b1;
				hold = $urandom_range(1, 17);
			end else begin
				smp_stall <= 1'b0;
				hold = quiet ? 1 : $urandom_range(1, 12);
			end
			repeat (hold - 1) @(posedge clk);
		end
	end

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return STEP_W'($urandom_range(300, 1700) * 97391);
			default: return STEP_W'($urandom);
		endcase
	endfunction

	task automatic queue_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
		reg_write_t w;
		w.idx = r;
		w.data = d;
		reg_plan.push_back(w);
		if (r == REG_LENGTH) begin
			cur_len = d[LEN_W-1:0];
		end
	endtask

	task automatic write_regs();
		reg_write_t w;
		while (reg_plan.size() != 0) begin
			w = reg_plan.pop_front();
			cfg_valid <= 1'b1;
			cfg_index <= w.idx;
			cfg_data <= w.data;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic play_ticks();
		while (tick_plan.size() != 0) begin
			if (!quiet && noisy && $urandom_range(0, 5) == 0) begin
				tick_valid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			tick_valid <= 1'b1;
			restart <= tick_plan.pop_front();
			do @(posedge clk); while (tick_stall);
			ticks_sent++;
			quiet = (ticks_sent >= TICK_ITEMS - QUIET_ITEMS);
		end
		tick_valid <= 1'b0;
	endtask

	// Wait for every due sample, then let any idle tick still in flight drain
	task automatic settle();
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin : stimulus
		bit fresh;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle tick, then restart with zero length: neither plays
		tick_plan = '{1'b0, 1'b1};
		play_ticks();
		settle();

		// one-sample dual tone at full steps, then an idle tick
		queue_reg(REG_STEP_FIRST, '1);
		queue_reg(REG_STEP_SECOND, 32'h8000_0000);
		queue_reg(REG_DUAL, 32'd1);
		queue_reg(REG_LENGTH, 32'd1);
		write_regs();
		tick_plan = '{1'b1, 1'b0};
		play_ticks();
		settle();

		queue_reg(REG_DUAL, 32'd0);
		queue_reg(REG_STEP_FIRST, 32'h4000_0000);
		queue_reg(REG_LENGTH, 32'd2);
		write_regs();
		tick_plan = '{1'b1, 1'b0, 1'b0};
		play_ticks();
		settle();

		// longest tone, receiver held off so the block backs up; restart while playing
		queue_reg(REG_DUAL, 32'd1);
		queue_reg(REG_STEP_FIRST, $urandom);
		queue_reg(REG_STEP_SECOND, 32'd0);
		queue_reg(REG_LENGTH, 32'h00FF_FFFF);
		write_regs();
		hold_req = 1'b1;
		tick_plan = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
		play_ticks();
		settle();

		// shrink the length below the current index mid-tone: zero sample, flagged last
		queue_reg(REG_LENGTH, 32'd1);
		write_regs();
		tick_plan = '{1'b0, 1'b0};
		play_ticks();
		settle();

		while (ticks_sent < TICK_ITEMS) begin
			noisy = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 1) == 1) begin
				queue_reg(REG_STEP_FIRST, pick_step());
			end
			if ($urandom_range(0, 1) == 1) begin
				queue_reg(REG_STEP_SECOND, pick_step());
			end
			if ($urandom_range(0, 2) == 0) begin
				queue_reg(REG_DUAL, $urandom_range(0, 1));
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 11))
					0: queue_reg(REG_LENGTH, 32'd0);
					1: queue_reg(REG_LENGTH, 32'h00FF_FFFF);
					2: queue_reg(REG_LENGTH, $urandom & 32'h00FF_FFFF);
					3: queue_reg(REG_LENGTH, $urandom_range(200, 480));
					default: queue_reg(REG_LENGTH, $urandom_range(1, 40));
				endcase
			end
			write_regs();
			// mostly whole tones from a restart; otherwise carry on or scatter restarts
			fresh = ($urandom_range(0, 4) != 0);
			if (!fresh || cur_len == 0 || cur_len > 600) begin
				n = $urandom_range(1, 30);
			end else begin
				n = int'(cur_len) + $urandom_range(0, 3);
			end
			// stop at the planned tick count
			if (n > TICK_ITEMS - ticks_sent) begin
				n = TICK_ITEMS - ticks_sent;
			end
			for (int k = 0; k < n; k++) begin
				if (k == 0) begin
					tick_plan.push_back(fresh);
				end else if (fresh) begin
					tick_plan.push_back($urandom_range(0, 59) == 0);
				end else begin
					tick_plan.push_back($urandom_range(0, 7) == 0);
				end
			end
			play_ticks();
			settle();
		end

		if (failures == 0 && pending == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== dual_tone_sample_generator_top.f =====
src/dtsg_pkg.sv
src/dtsg_cfg.sv
src/dtsg_ctrl.sv
src/dtsg_dp.sv
src/dual_tone_sample_generator_top.sv
dv/dtsg_checker.sv
dv/tb.sv
